/* hw/rtl/div_tima_timer_step_top_defines.svh */
// Assertion helpers shared by the timer RTL.
// Each macro expands to a labelled concurrent assertion, or to nothing in synthesis.
`ifndef DIV_TIMA_TIMER_STEP_TOP_DEFINES_SVH
`define DIV_TIMA_TIMER_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DTT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DTT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hw/rtl/dtt_pkg.sv */
package dtt_pkg;

  localparam int ACC_W  = 16;  // cycle accumulators and divider dividend
  localparam int PER_W  = 11;  // divisors up to 2047
  localparam int CNT_W  = 8;   // DIV and TIMA
  localparam int DOTS_W = 10;
  localparam int TAC_W  = 3;
  localparam int DATA_W = 24;  // both stream buses, padded to whole bytes
  localparam int STEP_W = $clog2(ACC_W + 1);

  localparam int TAC_EN_BIT = 2;

  localparam int DOTS_PER_CYCLE_DEF = 4;
  localparam int DIV_PERIOD_DEF     = 64;
  localparam int PERIOD_SEL0_DEF    = 256;
  localparam int PERIOD_SEL1_DEF    = 4;
  localparam int PERIOD_SEL2_DEF    = 16;
  localparam int PERIOD_SEL3_DEF    = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CYC,
    ST_ACC,
    ST_DIVW,
    ST_TST,
    ST_TIMAW,
    ST_WRST,
    ST_WRAPW,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quotient;
    logic [PER_W-1:0] remainder;
  } div_rsp_t;

  // A period of zero is replaced by one.
  function automatic logic [PER_W-1:0] safe_period(int p);
    logic [PER_W-1:0] r;
    r = (p == 0) ? PER_W'(1) : p[PER_W-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/div_tima_timer_step_top.sv */
// DIV/TIMA timer stepped by spans of elapsed dot clocks. Each request carries the dots
// since the previous step plus the DIV-write, stop, TAC and TMA inputs; it yields one
// result with DIV, TIMA and the overflow interrupt flag. All divisions (dots to machine
// cycles, DIV ticks, TIMA ticks and the TMA wrap) run on one shared restoring divider
// that resolves one quotient bit per clock, and a step needs one to four divisions.
// A stopped CPU skips the DIV division, a disabled timer skips the TIMA divisions, and
// the wrap division is only run when TIMA overflows. s_tready is high only while the
// sequencer is idle; a finished result sits in the output register until taken, and
// the next request may be accepted meanwhile.
`include "div_tima_timer_step_top_defines.svh"

module div_tima_timer_step_top #(
  parameter int DOTS_PER_CYCLE = dtt_pkg::DOTS_PER_CYCLE_DEF,
  parameter int DIV_PERIOD     = dtt_pkg::DIV_PERIOD_DEF,
  parameter int PERIOD_SEL0    = dtt_pkg::PERIOD_SEL0_DEF,
  parameter int PERIOD_SEL1    = dtt_pkg::PERIOD_SEL1_DEF,
  parameter int PERIOD_SEL2    = dtt_pkg::PERIOD_SEL2_DEF,
  parameter int PERIOD_SEL3    = dtt_pkg::PERIOD_SEL3_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // dots[9:0], div_reset[10], stopped[11], tac[14:12], tma[22:15], zero pad[23]
  input  logic [dtt_pkg::DATA_W-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // div_value[7:0], tima_value[15:8], timer_irq[16], zero pad[23:17]
  output logic [dtt_pkg::DATA_W-1:0] m_tdata
);

  localparam logic [dtt_pkg::PER_W-1:0] DPC_DVS = dtt_pkg::safe_period(DOTS_PER_CYCLE);
  localparam logic [dtt_pkg::PER_W-1:0] DIV_DVS = dtt_pkg::safe_period(DIV_PERIOD);
  localparam logic [dtt_pkg::PER_W-1:0] PER_TAB [4] = '{
    dtt_pkg::safe_period(PERIOD_SEL0),
    dtt_pkg::safe_period(PERIOD_SEL1),
    dtt_pkg::safe_period(PERIOD_SEL2),
    dtt_pkg::safe_period(PERIOD_SEL3)
  };

  dtt_pkg::state_t state, state_next;
  dtt_pkg::div_req_t dv_req;
  dtt_pkg::div_rsp_t dv_rsp;

  // Request fields, held for the whole step.
  logic                       div_reset_r;
  logic                       stopped_r;
  logic [dtt_pkg::TAC_W-1:0]  tac_r;
  logic [dtt_pkg::CNT_W-1:0]  tma_r;

  // Timer state.
  logic [dtt_pkg::ACC_W-1:0]  div_accum;
  logic [dtt_pkg::ACC_W-1:0]  tima_accum;
  logic [dtt_pkg::CNT_W-1:0]  div_count;
  logic [dtt_pkg::CNT_W-1:0]  tima_count;
  logic                       irq_r;
  logic [dtt_pkg::ACC_W-1:0]  rest;

  logic [dtt_pkg::CNT_W-1:0]  div_out;
  logic [dtt_pkg::CNT_W-1:0]  tima_out;
  logic                       irq_out;

  logic                       in_acc;
  logic                       out_load;
  logic                       tima_en;
  logic [dtt_pkg::ACC_W:0]    tima_sum;
  logic [dtt_pkg::CNT_W:0]    span;

  assign in_acc  = s_tvalid && s_tready;
  assign tima_en = tac_r[dtt_pkg::TAC_EN_BIT];
  // TIMA plus its tick count; anything at or above 256 means overflow.
  assign tima_sum = {1'b0, dv_rsp.quotient} + (dtt_pkg::ACC_W + 1)'(tima_count);
  // Counting range after a reload: TMA up to 0xFF.
  assign span = (dtt_pkg::CNT_W + 1)'(1 << dtt_pkg::CNT_W) - {1'b0, tma_r};

  dtt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: each wait state hands over when the divider reports done.
  always_comb begin
    state_next = state;
    case (state)
      dtt_pkg::ST_IDLE: begin
        if (in_acc) state_next = dtt_pkg::ST_CYC;
      end
      dtt_pkg::ST_CYC: begin
        if (dv_rsp.done) state_next = dtt_pkg::ST_ACC;
      end
      dtt_pkg::ST_ACC: begin
        state_next = stopped_r ? dtt_pkg::ST_TST : dtt_pkg::ST_DIVW;
      end
      dtt_pkg::ST_DIVW: begin
        if (dv_rsp.done) state_next = dtt_pkg::ST_TST;
      end
      dtt_pkg::ST_TST: begin
        state_next = tima_en ? dtt_pkg::ST_TIMAW : dtt_pkg::ST_EMIT;
      end
      dtt_pkg::ST_TIMAW: begin
        if (dv_rsp.done) begin
          if (tima_sum[dtt_pkg::ACC_W:dtt_pkg::CNT_W] == '0) begin
            state_next = dtt_pkg::ST_EMIT;
          end else begin
            state_next = dtt_pkg::ST_WRST;
          end
        end
      end
      dtt_pkg::ST_WRST: begin
        state_next = dtt_pkg::ST_WRAPW;
      end
      dtt_pkg::ST_WRAPW: begin
        if (dv_rsp.done) state_next = dtt_pkg::ST_EMIT;
      end
      dtt_pkg::ST_EMIT: begin
        if (out_load) state_next = dtt_pkg::ST_IDLE;
      end
      default: begin
        state_next = dtt_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: divider operands per state, request ready, result load.
  always_comb begin
    dv_req.start    = 1'b0;
    dv_req.dividend = '0;
    dv_req.divisor  = DPC_DVS;
    s_tready        = 1'b0;
    out_load        = 1'b0;
    case (state)
      dtt_pkg::ST_IDLE: begin
        // Hold off requests while in reset.
        s_tready        = !rst;
        dv_req.start    = s_tvalid && !rst;
        dv_req.dividend = dtt_pkg::ACC_W'(s_tdata[dtt_pkg::DOTS_W-1:0]);
        dv_req.divisor  = DPC_DVS;
      end
      dtt_pkg::ST_ACC: begin
        dv_req.start    = !stopped_r;
        dv_req.dividend = div_accum;
        dv_req.divisor  = DIV_DVS;
      end
      dtt_pkg::ST_TST: begin
        dv_req.start    = tima_en;
        dv_req.dividend = tima_accum;
        dv_req.divisor  = PER_TAB[tac_r[1:0]];
      end
      dtt_pkg::ST_WRST: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = rest;
        dv_req.divisor  = dtt_pkg::PER_W'(span);
      end
      dtt_pkg::ST_EMIT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        dv_req.start = 1'b0;
      end
    endcase
  end

  // Latch the request; the next block starts each step from a clear interrupt flag.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      div_reset_r <= s_tdata[10];
      stopped_r   <= s_tdata[11];
      tac_r       <= s_tdata[14:12];
      tma_r       <= s_tdata[22:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_accum  <= '0;
      tima_accum <= '0;
      div_count  <= '0;
      tima_count <= '0;
      irq_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        irq_r <= 1'b0;
      end
      if (dv_rsp.done) begin
        case (state)
          dtt_pkg::ST_CYC: begin
            // Add this step's machine cycles; a DIV write clears DIV first.
            if (div_reset_r) begin
              div_accum <= dv_rsp.quotient;
              div_count <= '0;
            end else begin
              div_accum <= div_accum + dv_rsp.quotient;
            end
            tima_accum <= tima_accum + dv_rsp.quotient;
          end
          dtt_pkg::ST_DIVW: begin
            div_accum <= dtt_pkg::ACC_W'(dv_rsp.remainder);
            div_count <= div_count + dv_rsp.quotient[dtt_pkg::CNT_W-1:0];
          end
          dtt_pkg::ST_TIMAW: begin
            tima_accum <= dtt_pkg::ACC_W'(dv_rsp.remainder);
            if (tima_sum[dtt_pkg::ACC_W:dtt_pkg::CNT_W] == '0) begin
              tima_count <= tima_sum[dtt_pkg::CNT_W-1:0];
            end else begin
              irq_r <= 1'b1;
            end
          end
          dtt_pkg::ST_WRAPW: begin
            // Reload from TMA and keep counting inside its range.
            tima_count <= tma_r + dv_rsp.remainder[dtt_pkg::CNT_W-1:0];
          end
          default: begin
            irq_r <= irq_r;
          end
        endcase
      end
    end
  end

  // Ticks left after the first overflow from 0xFF.
  always_ff @(posedge clk) begin
    if (state == dtt_pkg::ST_TIMAW && dv_rsp.done) begin
      rest <= dtt_pkg::ACC_W'(tima_sum - (dtt_pkg::ACC_W + 1)'(1 << dtt_pkg::CNT_W));
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      div_out  <= div_count;
      tima_out <= tima_count;
      irq_out  <= irq_r;
    end
  end

  assign m_tdata = {7'b0, irq_out, tima_out, div_out};

  `DTT_ASSERT_NXT(a_accept_starts, clk, rst, in_acc, state == dtt_pkg::ST_CYC, "accepted request did not start the cycle division")
  `DTT_ASSERT_IMP(a_done_in_wait, clk, rst, dv_rsp.done, state == dtt_pkg::ST_CYC || state == dtt_pkg::ST_DIVW || state == dtt_pkg::ST_TIMAW || state == dtt_pkg::ST_WRAPW, "divider finished outside a wait state")
  `DTT_ASSERT_IMP(a_wrap_has_irq, clk, rst, state == dtt_pkg::ST_WRAPW, irq_r, "wrap division without overflow flag")
  `DTT_ASSERT_NXT(a_emit_loads, clk, rst, out_load, m_tvalid && state == dtt_pkg::ST_IDLE, "result load did not present a result")

endmodule

/* hw/rtl/dtt_divider.sv */
// Restoring divider: one quotient bit per cycle, done pulses when results are final.
module dtt_divider (
  input  logic              clk,
  input  logic              rst,
  input  dtt_pkg::div_req_t req,
  output dtt_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic [dtt_pkg::STEP_W-1:0]  cnt;
  logic [dtt_pkg::ACC_W-1:0]   quo;
  logic [dtt_pkg::PER_W-1:0]   rem;
  logic [dtt_pkg::PER_W-1:0]   dvs;
  logic [dtt_pkg::PER_W:0]     shifted;
  logic                        fits;

  assign shifted = {rem, quo[dtt_pkg::ACC_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == dtt_pkg::STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= dtt_pkg::STEP_W'(dtt_pkg::ACC_W);
      end else if (busy) begin
        cnt <= cnt - dtt_pkg::STEP_W'(1);
        if (cnt == dtt_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[dtt_pkg::ACC_W-2:0], fits};
      if (fits) begin
        rem <= dtt_pkg::PER_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[dtt_pkg::PER_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
